@@ src/nmea_gll_position_parser_macros.svh @@
// Assertion macros used by the GLL parser converter back end.
// Needs clk and rst_n in the scope of each use.
`ifndef NMEA_GLL_POSITION_PARSER_MACROS_SVH
`define NMEA_GLL_POSITION_PARSER_MACROS_SVH

// Check a property on every clock, idle during reset.
`define NGLL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another one in the following cycle.
`define NGLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ngll_pkg.sv @@
// Shared types, constants and helper functions for the GLL position parser.
// No dependencies.
package ngll_pkg;

    localparam int FRAC_DIGITS_DEF = 5;
    localparam int FRAC_W          = 24;  // fraction of minutes, up to 10^7 - 1
    localparam int WHOLE_W         = 7;   // whole minutes, saturating at 99
    localparam int DEG_W           = 10;  // up to three degree digits
    localparam int MS_W            = 30;  // scaled minutes, below 100 * 10^7
    localparam int MAG_W           = 34;
    localparam int POS_W           = 35;
    localparam int QUEUE_DEPTH     = 4;
    localparam int PTR_W           = $clog2(QUEUE_DEPTH);

    localparam logic [WHOLE_W-1:0] WHOLE_MAX = 7'd99;
    localparam logic [23:0]        DEG_SCALE = 24'd10000000;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    // Token positions within a sentence
    localparam logic [3:0] TOK_LAT      = 4'd2;
    localparam logic [3:0] TOK_LAT_HEMI = 4'd3;
    localparam logic [3:0] TOK_LON      = 4'd4;
    localparam logic [3:0] TOK_LON_HEMI = 4'd5;
    localparam logic [3:0] TOK_STATUS   = 4'd7;
    localparam logic [3:0] TOK_COUNT    = 4'd8;
    localparam logic [3:0] TOK_MAX      = 4'd15;

    // Minutes parse state of the current token
    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [2:0]         cnt;
        logic               stopped;
        logic               in_frac;
    } min_t;

    // One beat from the tokenizer to the converter
    typedef struct packed {
        logic               conv;      // a position token ended
        logic               conv_lon;  // it was the longitude
        logic [DEG_W-1:0]   deg;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic               is_end;    // line feed: emit a result
        logic               valid;
        logic               lat_neg;
        logic               lon_neg;
    } job_t;

    function automatic logic [23:0] pow10(input int unsigned n);
        logic [23:0] r;
        unique case (n)
            0: r = 24'd1;
            1: r = 24'd10;
            2: r = 24'd100;
            3: r = 24'd1000;
            4: r = 24'd10000;
            5: r = 24'd100000;
            6: r = 24'd1000000;
            7: r = 24'd10000000;
            default: r = 24'd1;
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Feed one character into the minutes parse
    function automatic min_t feed(input min_t m, input logic [7:0] c, input int unsigned f);
        min_t        r;
        logic [3:0]  d;
        logic [9:0]  w;
        int unsigned idx;
        r   = m;
        d   = 4'(c - CH_ZERO);
        w   = 10'(m.whole) * 10'd10 + 10'(d);
        idx = f - 1 - int'(m.cnt);
        if (!m.stopped) begin
            if (is_digit(c)) begin
                if (!m.in_frac) begin
                    r.whole = (w > 10'(WHOLE_MAX)) ? WHOLE_MAX : w[WHOLE_W-1:0];
                end
                else if (int'(m.cnt) < f) begin
                    r.frac = m.frac + FRAC_W'({20'd0, d} * pow10(idx));
                    r.cnt  = m.cnt + 3'd1;
                end
            end
            else if (c == CH_DOT && !m.in_frac) begin
                r.in_frac = 1'b1;
            end
            else begin
                r.stopped = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

@@ src/ngll_front.sv @@
// Tokenizer front end: splits characters into tokens, parses position tokens
// and pushes conversion and end-of-sentence beats. Depends on ngll_pkg.
module ngll_front #(
    parameter int FRAC_DIGITS = ngll_pkg::FRAC_DIGITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          char_in,
    output logic                job_valid,
    output ngll_pkg::job_t      job,
    input  logic                job_full
);
    import ngll_pkg::*;

    logic [3:0] tok_num_reg, tok_num_next;
    logic       in_token_reg, in_token_next;
    logic [2:0] tok_len_reg, tok_len_next;   // saturates at 6 (longer than five)
    logic [7:0] prefix_reg [5];
    logic [7:0] prefix_next [5];
    min_t       min_reg, min_next;
    logic       lat_neg_reg, lat_neg_next;
    logic       lon_neg_reg, lon_neg_next;
    logic       status_a_reg, status_a_next;

    logic       accept;
    logic       conv_hit;
    logic       long_tok;
    logic [DEG_W-1:0] deg;

    assign full   = job_full;
    assign accept = push && !job_full;

    // Degrees from the stored prefix
    always_comb
    begin
        logic run;
        logic dc3;
        run = 1'b1;
        dc3 = (prefix_reg[4] != CH_DOT);
        deg = '0;
        for (int i = 0; i < 3; i++)
        begin
            if ((i < 2 || dc3) && run) begin
                if (is_digit(prefix_reg[i])) begin
                    deg = DEG_W'(deg * DEG_W'(10) + DEG_W'(prefix_reg[i] - CH_ZERO));
                end
                else begin
                    run = 1'b0;
                end
            end
        end
    end

    assign long_tok = (tok_len_reg == 3'd6);
    assign conv_hit = in_token_reg && (tok_num_reg == TOK_LAT || tok_num_reg == TOK_LON);

    // Advance token state, build the beat
    always_comb
    begin
        logic [3:0] tn;
        logic [2:0] len;
        min_t       m;
        tok_num_next  = tok_num_reg;
        in_token_next = in_token_reg;
        tok_len_next  = tok_len_reg;
        prefix_next   = prefix_reg;
        min_next      = min_reg;
        lat_neg_next  = lat_neg_reg;
        lon_neg_next  = lon_neg_reg;
        status_a_next = status_a_reg;
        tn            = tok_num_reg;
        len           = tok_len_reg;
        m             = min_reg;

        job_valid    = 1'b0;
        job          = '0;
        job.conv     = conv_hit;
        job.conv_lon = (tok_num_reg == TOK_LON);
        job.deg      = long_tok ? deg : '0;
        job.whole    = long_tok ? min_reg.whole : '0;
        job.frac     = long_tok ? min_reg.frac : '0;
        job.valid    = (tok_num_reg == TOK_COUNT) && status_a_reg;
        job.lat_neg  = lat_neg_reg;
        job.lon_neg  = lon_neg_reg;

        if (accept) begin
            if (char_in == CH_LF) begin
                // end of sentence: emit and clear
                job_valid     = 1'b1;
                job.is_end    = 1'b1;
                tok_num_next  = '0;
                in_token_next = 1'b0;
                tok_len_next  = '0;
                min_next      = '0;
                lat_neg_next  = 1'b0;
                lon_neg_next  = 1'b0;
                status_a_next = 1'b0;
            end
            else if (char_in == CH_COMMA) begin
                job_valid     = conv_hit;
                in_token_next = 1'b0;
            end
            else begin
                if (!in_token_reg) begin
                    // open a new token
                    in_token_next = 1'b1;
                    tn  = (tok_num_reg == TOK_MAX) ? TOK_MAX : tok_num_reg + 4'd1;
                    len = '0;
                    m   = '0;
                    if (tn == TOK_LAT_HEMI) begin
                        lat_neg_next = (char_in == CH_S);
                    end
                    else if (tn == TOK_LON_HEMI) begin
                        lon_neg_next = (char_in == CH_W);
                    end
                    else if (tn == TOK_STATUS) begin
                        status_a_next = (char_in == CH_A);
                    end
                end
                else if (tok_num_reg == TOK_STATUS) begin
                    status_a_next = 1'b0;
                end

                if (len < 3'd5) begin
                    prefix_next[len] = char_in;
                    if (len == 3'd4) begin
                        // prefix complete: feed the minutes part of it
                        if (char_in == CH_DOT) begin
                            m = feed(m, prefix_reg[2], FRAC_DIGITS);
                        end
                        m = feed(m, prefix_reg[3], FRAC_DIGITS);
                        m = feed(m, char_in, FRAC_DIGITS);
                    end
                end
                else begin
                    m = feed(m, char_in, FRAC_DIGITS);
                end
                tok_num_next = tn;
                tok_len_next = (len == 3'd6) ? 3'd6 : len + 3'd1;
                min_next     = m;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_num_reg  <= '0;
            in_token_reg <= 1'b0;
            tok_len_reg  <= '0;
            min_reg      <= '0;
            lat_neg_reg  <= 1'b0;
            lon_neg_reg  <= 1'b0;
            status_a_reg <= 1'b0;
        end
        else begin
            tok_num_reg  <= tok_num_next;
            in_token_reg <= in_token_next;
            tok_len_reg  <= tok_len_next;
            min_reg      <= min_next;
            lat_neg_reg  <= lat_neg_next;
            lon_neg_reg  <= lon_neg_next;
            status_a_reg <= status_a_next;
        end
    end

    // Prefix characters, no reset
    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
    end

endmodule

@@ src/ngll_fifo.sv @@
// Short queue of beats between tokenizer and converter.
// Depends on ngll_pkg.
module ngll_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  ngll_pkg::job_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output ngll_pkg::job_t rd_data,
    output logic           empty
);
    import ngll_pkg::*;

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (do_rd && !do_wr) begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    // Store beats
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ src/ngll_back.sv @@
// Converter back end: scales minutes, divides by 60, adds degrees, latches
// positions and holds the result beat. Depends on ngll_pkg and the macro header.
`include "nmea_gll_position_parser_macros.svh"
module ngll_back #(
    parameter int FRAC_DIGITS = ngll_pkg::FRAC_DIGITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_avail,
    input  ngll_pkg::job_t                    job,
    output logic                              job_rd,
    output logic                              empty,
    input  logic                              pop,
    output logic                              fix_valid,
    output logic signed [ngll_pkg::POS_W-1:0] latitude,
    output logic signed [ngll_pkg::POS_W-1:0] longitude
);
    import ngll_pkg::*;

    localparam logic [23:0] MIN_UNIT  = pow10(FRAC_DIGITS);
    localparam logic [23:0] MIN_SCALE = pow10(7 - FRAC_DIGITS);
    localparam logic [28:0] DIV15_K   = 29'd286331154;  // ceil(2^32 / 15)

    typedef struct packed {
        logic conv;
        logic conv_lon;
        logic is_end;
        logic valid;
        logic lat_neg;
        logic lon_neg;
    } ctl_t;

    logic             adv;
    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg;
    ctl_t             s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic [DEG_W-1:0] s1_deg_reg;
    logic [MS_W-1:0]  s1_ms_reg;
    logic [MAG_W-1:0] s2_degs_reg, s3_degs_reg;
    logic [MS_W-1:0]  s2_x_reg;
    logic [24:0]      s3_q_reg;
    logic [56:0]      prod15;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] lat_mag_reg, lat_mag_next;
    logic [MAG_W-1:0] lon_mag_reg, lon_mag_next;
    logic [MAG_W-1:0] lat_now, lon_now;
    logic             out_valid_reg, out_valid_next;
    logic             fix_reg;
    logic [POS_W-1:0] lat_out_reg, lon_out_reg;
    ctl_t             in_ctl;

    assign adv    = !out_valid_reg || pop;
    assign job_rd = adv && job_avail;

    assign in_ctl = '{conv: job.conv, conv_lon: job.conv_lon, is_end: job.is_end,
                      valid: job.valid, lat_neg: job.lat_neg, lon_neg: job.lon_neg};

    // Divide by 60: drop two bits, then multiply by reciprocal of 15
    assign prod15 = 57'(s2_x_reg[MS_W-1:2]) * 57'(DIV15_K);
    assign mag    = s3_degs_reg + MAG_W'(s3_q_reg);

    // Latch positions, fold the final stage into the result
    always_comb
    begin
        lat_now        = (s3_ctl_reg.conv && !s3_ctl_reg.conv_lon) ? mag : lat_mag_reg;
        lon_now        = (s3_ctl_reg.conv && s3_ctl_reg.conv_lon) ? mag : lon_mag_reg;
        lat_mag_next   = lat_mag_reg;
        lon_mag_next   = lon_mag_reg;
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = s3_valid_reg && s3_ctl_reg.is_end;
            if (s3_valid_reg) begin
                lat_mag_next = s3_ctl_reg.is_end ? '0 : lat_now;
                lon_mag_next = s3_ctl_reg.is_end ? '0 : lon_now;
            end
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lat_mag_reg   <= '0;
            lon_mag_reg   <= '0;
        end
        else begin
            if (adv) begin
                s1_valid_reg <= job_avail;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            out_valid_reg <= out_valid_next;
            lat_mag_reg   <= lat_mag_next;
            lon_mag_reg   <= lon_mag_next;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_ctl_reg  <= in_ctl;
            s1_deg_reg  <= job.deg;
            s1_ms_reg   <= MS_W'(MS_W'(job.whole) * MS_W'(MIN_UNIT)) + MS_W'(job.frac);
            s2_ctl_reg  <= s1_ctl_reg;
            s2_degs_reg <= MAG_W'(s1_deg_reg) * MAG_W'(DEG_SCALE);
            s2_x_reg    <= MS_W'(s1_ms_reg * MS_W'(MIN_SCALE));
            s3_ctl_reg  <= s2_ctl_reg;
            s3_degs_reg <= s2_degs_reg;
            s3_q_reg    <= prod15[56:32];
            if (s3_valid_reg && s3_ctl_reg.is_end) begin
                fix_reg     <= s3_ctl_reg.valid;
                lat_out_reg <= !s3_ctl_reg.valid ? '0 :
                               s3_ctl_reg.lat_neg ? POS_W'(-{1'b0, lat_now}) : {1'b0, lat_now};
                lon_out_reg <= !s3_ctl_reg.valid ? '0 :
                               s3_ctl_reg.lon_neg ? POS_W'(-{1'b0, lon_now}) : {1'b0, lon_now};
            end
        end
    end

    assign empty     = !out_valid_reg;
    assign fix_valid = fix_reg;
    assign latitude  = signed'(lat_out_reg);
    assign longitude = signed'(lon_out_reg);

    `NGLL_ASSERT(a_invalid_zero, out_valid_reg && !fix_reg |-> lat_out_reg == '0 && lon_out_reg == '0, "invalid result carries a position")
    `NGLL_ASSERT_NEXT(a_stall_hold, out_valid_reg && !pop, out_valid_reg && $stable(lat_out_reg) && $stable(lon_out_reg), "stalled result changed")
    `NGLL_ASSERT_NEXT(a_mag_clear, adv && s3_valid_reg && s3_ctl_reg.is_end, lat_mag_reg == '0 && lon_mag_reg == '0, "positions not cleared after sentence")

endmodule

@@ src/nmea_gll_position_parser.sv @@
// A line feed accepted passes through the beat queue, converter stages s1 to s3 and the result register.
// Throughput: one character per cycle while full is low; tokenizer and converter run decoupled.
// The converter pipeline holds only while its result beat is not taken.
// Reset clears token state, queue and pipeline at once; no clearing pass.
// Depends on ngll_pkg, ngll_front, ngll_fifo, ngll_back.
module nmea_gll_position_parser #(
    parameter int FRAC_DIGITS = ngll_pkg::FRAC_DIGITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        char_in,
    output logic                              empty,
    input  logic                              pop,
    output logic                              fix_valid,
    output logic signed [ngll_pkg::POS_W-1:0] latitude,
    output logic signed [ngll_pkg::POS_W-1:0] longitude
);
    import ngll_pkg::*;

    logic job_wr;
    job_t job_in;
    logic q_full;
    logic q_rd;
    job_t q_data;
    logic q_empty;

    ngll_front #(.FRAC_DIGITS(FRAC_DIGITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_in   (char_in),
        .job_valid (job_wr),
        .job       (job_in),
        .job_full  (q_full)
    );

    ngll_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (job_in),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    ngll_back #(.FRAC_DIGITS(FRAC_DIGITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job       (q_data),
        .job_rd    (q_rd),
        .empty     (empty),
        .pop       (pop),
        .fix_valid (fix_valid),
        .latitude  (latitude),
        .longitude (longitude)
    );

endmodule

@@ bench/gll_fix_checker.sv @@
// Checker for the GLL position parser: watches both queue channels,
// predicts each fix from the accepted characters and compares the results.
// Depends on ngll_pkg.
`timescale 1ns / 100ps

module gll_fix_checker #(
    parameter int FRAC_DIGITS = ngll_pkg::FRAC_DIGITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic [7:0]                        char_in,
    input  logic                              empty,
    input  logic                              pop,
    input  logic                              fix_valid,
    input  logic signed [ngll_pkg::POS_W-1:0] latitude,
    input  logic signed [ngll_pkg::POS_W-1:0] longitude,
    output int                                errors,
    output int                                pending
);
    import ngll_pkg::*;

    typedef struct {
        logic               ok;
        logic [POS_W-1:0]   lat;
        logic [POS_W-1:0]   lon;
    } fix_t;

    fix_t fix_q[$];

    int                tok_num;
    int                tok_len;
    bit                in_tok;
    logic [7:0]        pfx[5];
    longint unsigned   min_scaled;
    int                frac_cnt;
    bit                num_stopped;
    bit                num_in_frac;
    longint unsigned   lat_mag;
    longint unsigned   lon_mag;
    bit                lat_south;
    bit                lon_west;
    bit                status_a;

    assign pending = fix_q.size();

    function automatic longint unsigned ten_pow(int n);
        longint unsigned r;
        r = 1;
        repeat (n) r = r * 10;
        return r;
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_sentence();
        tok_num = 0; tok_len = 0; in_tok = 0;
        foreach (pfx[i]) pfx[i] = 8'd0;
        min_scaled = 0; frac_cnt = 0; num_stopped = 0; num_in_frac = 0;
        lat_mag = 0; lon_mag = 0; lat_south = 0; lon_west = 0; status_a = 0;
    endfunction

    // Advance the minutes parse by one character
    function automatic void add_minute_char(logic [7:0] c);
        longint unsigned whole;
        if (num_stopped)
            return;
        if (digit(c)) begin
            if (!num_in_frac) begin
                whole = min_scaled / ten_pow(FRAC_DIGITS) * 10 + (c - CH_ZERO);
                if (whole > 99)
                    whole = 99;
                min_scaled = whole * ten_pow(FRAC_DIGITS);
            end
            else if (frac_cnt < FRAC_DIGITS) begin
                min_scaled += (c - CH_ZERO) * ten_pow(FRAC_DIGITS - 1 - frac_cnt);
                frac_cnt++;
            end
        end
        else if (c == CH_DOT && !num_in_frac)
            num_in_frac = 1;
        else
            num_stopped = 1;
    endfunction

    function automatic int deg_chars();
        return (pfx[4] == CH_DOT) ? 2 : 3;
    endfunction

    function automatic longint unsigned position_mag();
        longint unsigned deg;
        deg = 0;
        if (tok_len <= 5)
            return 0;
        for (int i = 0; i < deg_chars(); i++) begin
            if (!digit(pfx[i]))
                break;
            deg = deg * 10 + (pfx[i] - CH_ZERO);
        end
        return deg * 64'd10000000
             + (min_scaled * 64'd10000000) / (60 * ten_pow(FRAC_DIGITS));
    endfunction

    function automatic void close_token();
        if (tok_num == 2)
            lat_mag = position_mag();
        else if (tok_num == 4)
            lon_mag = position_mag();
        in_tok = 0;
    endfunction

    function automatic void take_token_char(logic [7:0] c);
        if (!in_tok) begin
            in_tok = 1;
            if (tok_num < 15)
                tok_num++;
            tok_len = 0; min_scaled = 0; frac_cnt = 0;
            num_stopped = 0; num_in_frac = 0;
            if (tok_num == 3)
                lat_south = (c == CH_S);
            else if (tok_num == 5)
                lon_west = (c == CH_W);
            else if (tok_num == 7)
                status_a = (c == CH_A);
        end
        else if (tok_num == 7)
            status_a = 0;
        if (tok_len < 5) begin
            pfx[tok_len] = c;
            if (tok_len == 4)
                for (int i = deg_chars(); i < 5; i++)
                    add_minute_char(pfx[i]);
        end
        else
            add_minute_char(c);
        if (tok_len < 127)
            tok_len++;
    endfunction

    // Predict on each accepted character; queue a fix on line feed
    function automatic void predict_char(logic [7:0] c);
        fix_t f;
        if (c == CH_LF) begin
            if (in_tok)
                close_token();
            f.ok  = (tok_num == 8) && status_a;
            f.lat = !f.ok ? '0 : lat_south ? POS_W'(-lat_mag) : POS_W'(lat_mag);
            f.lon = !f.ok ? '0 : lon_west ? POS_W'(-lon_mag) : POS_W'(lon_mag);
            fix_q.push_back(f);
            clear_sentence();
        end
        else if (c == CH_COMMA) begin
            if (in_tok)
                close_token();
        end
        else
            take_token_char(c);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fix_t f;
        if (!rst_n) begin
            clear_sentence();
            fix_q.delete();
            errors <= 0;
        end
        else begin
            // Compare the result beat with the oldest prediction
            if (pop && !empty) begin
                if (fix_q.size() == 0) begin
                    $display("%0t: unexpected result beat valid=%0b lat=%0d lon=%0d",
                             $time, fix_valid, latitude, longitude);
                    errors <= errors + 1;
                end
                else begin
                    f = fix_q.pop_front();
                    if (fix_valid !== f.ok || latitude !== f.lat || longitude !== f.lon) begin
                        $display("%0t: expected valid=%0b lat=%0d lon=%0d, got valid=%0b lat=%0d lon=%0d",
                                 $time, f.ok, $signed(f.lat), $signed(f.lon),
                                 fix_valid, latitude, longitude);
                        errors <= errors + 1;
                    end
                end
            end
            if (push && !full)
                predict_char(char_in);
        end
    end
endmodule

@@ bench/tb.sv @@
// Top of the GLL parser bench: clock, reset, sentence stimulus and verdict.
// Depends on ngll_pkg, nmea_gll_position_parser and gll_fix_checker.
`timescale 1ns / 100ps

module tb;
    import ngll_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic [7:0]              char_in;
    logic                    empty;
    logic                    pop;
    logic                    fix_valid;
    logic signed [POS_W-1:0] latitude;
    logic signed [POS_W-1:0] longitude;
    int                      errors;
    int                      pending;
    int                      sent;
    bit                      hold_rx;
    bit                      hold_done;
    bit                      drain_done;
    bit                      tx_burst;
    bit                      rx_burst;
    byte unsigned            line[$];

    nmea_gll_position_parser DUT (.*);

    gll_fix_checker CHK (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // Send one character beat, then idle for a random gap
    task automatic send_char(byte unsigned c);
        int gap;
        push    <= 1'b1;
        char_in <= c;
        do @(posedge clk); while (full);
        sent++;
        gap = (tx_burst || hold_rx) ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 60) == 0)
            tx_burst = !tx_burst;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line();
        while (line.size() > 0)
            send_char(line.pop_front());
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line.push_back(s[i]);
    endtask

    task automatic add_digits(int n);
        repeat (n) line.push_back(8'h30 + $urandom_range(0, 9));
    endtask

    // Append a position token: degrees, minutes, optional fraction
    task automatic add_position(int deg_n);
        add_digits(deg_n);
        add_digits($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : 2);
        if ($urandom_range(0, 5) != 0)
            line.push_back(CH_DOT);
        add_digits($urandom_range(0, 9));
        if ($urandom_range(0, 7) == 0)
            line.push_back($urandom_range(0, 255));
    endtask

    task automatic add_sep();
        repeat ($urandom_range(0, 5) == 0 ? $urandom_range(2, 4) : 1)
            line.push_back(CH_COMMA);
    endtask

    // Build a mostly well-formed GLL sentence with random content
    task automatic add_sentence();
        int ntok;
        byte unsigned hemi[4] = '{CH_S, 8'h4E, CH_W, 8'h45};
        ntok = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : 8;
        if ($urandom_range(0, 3) == 0)
            line.push_back(CH_COMMA);
        for (int t = 1; t <= ntok; t++) begin
            if (t > 1)
                add_sep();
            case (t)
                2, 4:    add_position($urandom_range(0, 1) ? 2 : 3);
                3, 5:    line.push_back($urandom_range(0, 9) ? hemi[$urandom_range(0, 3)]
                                                             : $urandom_range(33, 126));
                7: begin
                    line.push_back($urandom_range(0, 5) ? CH_A : 8'h56);
                    if ($urandom_range(0, 7) == 0)
                        line.push_back($urandom_range(0, 255) == CH_LF ? CH_A : CH_A);
                end
                1:       add_text("$GPGLL");
                default: begin
                    add_digits($urandom_range(1, 6));
                    if ($urandom_range(0, 1))
                        add_text("*1F\r");
                end
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8)) line.push_back($urandom_range(0, 255));
        line.push_back(CH_LF);
    endtask

    // Result side: random stalls, a long hold-off on request
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_rx) begin
                pop <= 1'b0;
                repeat (600) @(posedge clk);
                hold_rx = 0;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 40) == 0)
                rx_burst = !rx_burst;
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        int wait_n;
        rst_n   = 1'b0;
        push    = 1'b0;
        char_in = 8'h00;
        sent    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty line, too many tokens, full fix south/west, minutes at 99, malformed positions, noise bytes
        add_text("\n,,,\n1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,A\n");
        add_text("$G,4916.45,S,12311.12,W,2,A,A\n");
        add_text("x,9x99.99999999,N,18099.12345678,E,0,A,Z\n");
        add_text("x,12345,S,1234,W,0,AB,Z\n");
        add_text("x,00.0.5,N,359+1.0,W,0,A,Z\n");
        line.push_back(8'hFF); line.push_back(8'h00); line.push_back(CH_LF);
        send_line();

        // Random sentences, with noise in between
        while (sent < 1650) begin
            if (sent > 800 && !hold_done) begin
                // Stall the result side while a burst of line feeds queues up
                hold_done = 1;
                hold_rx   = 1;
                repeat (30) line.push_back(CH_LF);
                send_line();
            end
            else if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 10)) line.push_back($urandom_range(0, 255));
                send_line();
            end
            else begin
                add_sentence();
                send_line();
            end
            if (sent > 1200 && !drain_done) begin
                // Pause input until every fix is drained
                drain_done = 1;
                push <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end
        push <= 1'b0;

        wait_n = 0;
        while (pending != 0 && wait_n < 20000) begin
            @(posedge clk);
            wait_n++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
